/* src/bipc_pkg.sv */
// Shared types, codes and constants for the block I/O pattern counter.
// Used by bipc_ctrl, bipc_dp and block_io_pattern_counter; depends on nothing.
package bipc_pkg;

  // Default depth of the device table
  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  // A sector is 512 bytes
  localparam int unsigned SECTOR_SHIFT = 9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_FILTER_ON  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEVICE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_FILTER_ON = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PROCESS    = CFG_IDX_W'(3);

  // Operation codes of the func field
  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FILTERED = 2'd1,
    ST_FULL     = 2'd2,
    ST_ABSENT   = 2'd3
  } status_code_t;

  // Result classification codes
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SEQ  = 2'd1,
    KIND_RAND = 2'd2
  } kind_code_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_READ,
    S_UPDATE,
    S_HOLD
  } state_t;

  // Per-device counters held in the counter memory
  typedef struct packed {
    logic [63:0] last_end;
    logic [31:0] seq_cnt;
    logic [31:0] rand_cnt;
    logic [63:0] bytes;
  } entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming word
    logic lookup;    // key compare, slot choice, filter check
    logic read;      // read counters of the chosen slot
    logic write;     // write updated counters back
    logic load_out;  // load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_event;  // the item updates a table entry
  } sts_t;

endpackage

/* src/bipc_ctrl.sv */
// Controller state machine of the block I/O pattern counter.
// Depends on bipc_pkg; drives the datapath bipc_dp through cmd_t.
module bipc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  bipc_pkg::sts_t sts,
  output bipc_pkg::cmd_t cmd
);
  import bipc_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.write    = sts.count_event;
        cmd.load_out = 1'b1;
        state_next   = S_HOLD;
      end
      S_HOLD: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/bipc_dp.sv */
// Datapath of the block I/O pattern counter: config registers, device key
// table with parallel compare, counter memory and result register.
// Depends on bipc_pkg; sequenced by bipc_ctrl.
module bipc_dp #(
  parameter int unsigned TABLE_ENTRIES = bipc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_valid,
  input  logic [bipc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  // input word
  input  logic                           func,
  input  logic [31:0]                    device,
  input  logic [63:0]                    start_sector,
  input  logic [31:0]                    sector_count,
  input  logic [31:0]                    process_id,
  // control
  input  bipc_pkg::cmd_t                 cmd,
  output bipc_pkg::sts_t                 sts,
  // result word
  output logic [1:0]                     status,
  output logic [1:0]                     kind,
  output logic [31:0]                    sequential_count,
  output logic [31:0]                    random_count,
  output logic [63:0]                    byte_total,
  output logic [63:0]                    next_expected_sector
);
  import bipc_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Configuration registers
  logic        dev_filter_on;
  logic [31:0] target_dev;
  logic        pid_filter_on;
  logic [31:0] target_pid;

  // Captured input word
  logic        func_q;
  logic [31:0] dev_q;
  logic [63:0] start_q;
  logic [31:0] count_q;
  logic [31:0] pid_q;

  // Key table
  logic [TABLE_ENTRIES-1:0] used;
  logic [31:0]              key [TABLE_ENTRIES];

  // Counter memory
  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data;

  // Lookup results
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free;
  logic [IDX_W-1:0] free_idx;
  logic             filtered;
  status_code_t     status_calc;

  logic [IDX_W-1:0] slot;
  logic             has_entry;
  logic             fresh;
  logic             count_event;
  status_code_t     status_q;

  // Update path
  entry_t     old_ent;
  entry_t     new_ent;
  kind_code_t kind_calc;

  // Configuration writes, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_filter_on <= 1'b0;
      target_dev    <= '0;
      pid_filter_on <= 1'b0;
      target_pid    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEVICE_FILTER_ON:  dev_filter_on <= cfg_data[0];
        CFG_TARGET_DEVICE:     target_dev    <= cfg_data;
        CFG_PROCESS_FILTER_ON: pid_filter_on <= cfg_data[0];
        CFG_TARGET_PROCESS:    target_pid    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q  <= func;
      dev_q   <= device;
      start_q <= start_sector;
      count_q <= sector_count;
      pid_q   <= process_id;
    end
  end

  // Parallel key compare and lowest free slot, lowest index wins
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (used[i] && key[i] == dev_q) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!used[i]) begin
        free     = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Filters: device first, then process
  assign filtered = (dev_filter_on && target_dev != dev_q) ||
                    (pid_filter_on && target_pid != pid_q);

  always_comb begin
    if (func_q == FUNC_QUERY) begin
      status_calc = hit ? ST_DONE : ST_ABSENT;
    end else if (filtered) begin
      status_calc = ST_FILTERED;
    end else if (hit || free) begin
      status_calc = ST_DONE;
    end else begin
      status_calc = ST_FULL;
    end
  end

  // Lookup result registers; a new device claims its slot here
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.lookup && func_q == FUNC_COUNT && !filtered && !hit && free) begin
      used[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      slot        <= hit ? hit_idx : free_idx;
      has_entry   <= (status_calc == ST_DONE);
      fresh       <= !hit;
      count_event <= (func_q == FUNC_COUNT) && (status_calc == ST_DONE);
      status_q    <= status_calc;
      if (func_q == FUNC_COUNT && !filtered && !hit && free) begin
        key[free_idx] <= dev_q;
      end
    end
  end

  assign sts.count_event = count_event;

  // Counter memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= mem[slot];
    end
    if (cmd.write) begin
      mem[slot] <= new_ent;
    end
  end

  // Classification and counter update; a freshly taken entry starts at zero
  always_comb begin
    old_ent   = fresh ? '0 : rd_data;
    new_ent   = old_ent;
    kind_calc = KIND_NONE;
    if (old_ent.last_end != 64'd0) begin
      if (old_ent.last_end == start_q) begin
        new_ent.seq_cnt = old_ent.seq_cnt + 32'd1;
        kind_calc       = KIND_SEQ;
      end else begin
        new_ent.rand_cnt = old_ent.rand_cnt + 32'd1;
        kind_calc        = KIND_RAND;
      end
      new_ent.bytes = old_ent.bytes +
                      {32'd0, count_q[31-SECTOR_SHIFT:0], SECTOR_SHIFT'(0)};
    end
    new_ent.last_end = start_q + {32'd0, count_q};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= status_q;
      if (count_event) begin
        kind                 <= kind_calc;
        sequential_count     <= new_ent.seq_cnt;
        random_count         <= new_ent.rand_cnt;
        byte_total           <= new_ent.bytes;
        next_expected_sector <= new_ent.last_end;
      end else if (has_entry) begin
        kind                 <= KIND_NONE;
        sequential_count     <= old_ent.seq_cnt;
        random_count         <= old_ent.rand_cnt;
        byte_total           <= old_ent.bytes;
        next_expected_sector <= old_ent.last_end;
      end else begin
        kind                 <= KIND_NONE;
        sequential_count     <= '0;
        random_count         <= '0;
        byte_total           <= '0;
        next_expected_sector <= '0;
      end
    end
  end

endmodule

/* src/block_io_pattern_counter.sv */
// Block I/O pattern counter, top level. A result word becomes valid after
// its input word is accepted and passes capture, lookup, read and update.
// One word is in flight at a time: the controller sequences the counter
// memory read-modify-write and takes a new word only after the result is taken.
// Reset: synchronous, clears the controller, config registers and the table
// valid bits; no clearing pass.
// Depends on bipc_pkg, bipc_ctrl and bipc_dp.
module block_io_pattern_counter #(
  parameter int unsigned TABLE_ENTRIES = bipc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bipc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [31:0]                    device,
  input  logic [63:0]                    start_sector,
  input  logic [31:0]                    sector_count,
  input  logic [31:0]                    process_id,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [1:0]                     kind,
  output logic [31:0]                    sequential_count,
  output logic [31:0]                    random_count,
  output logic [63:0]                    byte_total,
  output logic [63:0]                    next_expected_sector
);
  import bipc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  // Controller
  bipc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  bipc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid & cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .func                 (func),
    .device               (device),
    .start_sector         (start_sector),
    .sector_count         (sector_count),
    .process_id           (process_id),
    .cmd                  (cmd),
    .sts                  (sts),
    .status               (status),
    .kind                 (kind),
    .sequential_count     (sequential_count),
    .random_count         (random_count),
    .byte_total           (byte_total),
    .next_expected_sector (next_expected_sector)
  );

endmodule
